// ===== rtl/core/kit_pkg.sv =====
// Package for the keyframe interval tracker: widths, command and run-state codes,
// key reset values and the saturating time adder and subtractor.
// No dependencies.
package kit_pkg;

   localparam int TIME_W           = 32;
   localparam int CMD_W            = 3;
   localparam int IDX_W            = 3;
   localparam int RUN_W            = 2;
   localparam int OFFC_W           = 31;
   localparam int CSR_IDX_W        = 3;
   localparam int MAX_KEYS_DEFAULT = 7;
   localparam int KEY_STEP         = 65536;

   typedef logic signed [TIME_W-1:0] time_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [RUN_W-1:0]         run_type;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GOTO    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OFFSET  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ZERO    = 3'd4;

   // Run-state codes
   localparam run_type RUN_UNDER   = 2'd0;
   localparam run_type RUN_RUNNING = 2'd1;
   localparam run_type RUN_OVER    = 2'd2;

   // Register indexes: key_count, then key_0 upwards
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT = 3'd0;

   localparam idx_type KEY_COUNT_RESET = 3'd2;

   localparam time_type TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
   localparam time_type TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

   function automatic time_type key_reset(input int i);
      key_reset = time_type'(i * KEY_STEP);
   endfunction

   function automatic time_type sat_add(input time_type a, input time_type b);
      logic signed [TIME_W:0] s;
      s = {a[TIME_W-1], a} + {b[TIME_W-1], b};
      if (s[TIME_W] != s[TIME_W-1])
         sat_add = s[TIME_W] ? TIME_MIN : TIME_MAX;
      else
         sat_add = s[TIME_W-1:0];
   endfunction

   function automatic time_type sat_sub(input time_type a, input time_type b);
      logic signed [TIME_W:0] s;
      s = {a[TIME_W-1], a} - {b[TIME_W-1], b};
      if (s[TIME_W] != s[TIME_W-1])
         sat_sub = s[TIME_W] ? TIME_MIN : TIME_MAX;
      else
         sat_sub = s[TIME_W-1:0];
   endfunction

endpackage

// ===== rtl/core/keyframe_interval_tracker.sv =====
// Keyframe interval tracker top level: running time, key registers, locate logic
// and the result register.
// Depends on kit_pkg.
//
// Keeps a signed Q16.16 running time and places it among up to MAX_KEYS
// nondecreasing key times. Each request beat carries one command (in tuser)
// and produces exactly one response beat. Throughput is one beat per clock while
// the response side is not stalled. An accepted beat first updates the running
// time and interval registers (saturating add plus parallel key compares), then
// loads the response register (offset subtract and clamps) once it is free. The
// response register lets a new request be taken while a result waits. Key writes
// do not relocate the time and are to be made only while no beat is in flight.
module keyframe_interval_tracker #(
   parameter int MAX_KEYS = kit_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,  // time_value[31:0], interval_index[34:32]
   input  logic [kit_pkg::CMD_W-1:0]     req_tuser,  // command[2:0]
   // response
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // time_now[31:0], time_clamped[63:32], interval_now[66:64],
   // interval_offset[98:67], interval_offset_clamped[129:99], run_state[131:130],
   // index_rejected[132]
   output logic [135:0]                  rsp_tdata,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kit_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kit_pkg::TIME_W-1:0]    csr_data
);
   import kit_pkg::*;

   localparam idx_type MAX_N   = idx_type'(MAX_KEYS);
   localparam idx_type MAX_SEG = idx_type'(MAX_KEYS - 2);

   // configuration
   idx_type  kc_ff;
   time_type key_ff [MAX_KEYS];

   // architectural state, also the first pipeline stage's payload
   time_type time_ff, time_in;
   idx_type  seg_ff, seg_in;
   run_type  phase_ff, phase_in;
   logic     rej_ff, rej_in;
   logic     s1_valid_ff, s1_valid_in;

   // response register
   logic     rsp_valid_ff, rsp_valid_in;
   time_type out_time_ff, out_clamped_ff, out_off_ff;
   idx_type  out_seg_ff;
   logic [OFFC_W-1:0] out_offc_ff;
   run_type  out_run_ff;
   logic     out_rej_ff;

   logic     rsp_free, s1_adv, req_acc;
   idx_type  keys_used, last_idx;
   time_type key_first, key_last;

   logic [CMD_W-1:0] cmd;
   time_type         tv;
   idx_type          target;
   time_type         key_target, cand_time;
   logic             locate_en, reject;
   idx_type          loc_seg;
   run_type          loc_phase;

   time_type          clamped, off, key_start, key_next;
   idx_type           seg_sat;
   logic signed [TIME_W:0] len_full;
   logic [OFFC_W-1:0] len, offc;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kc_ff <= KEY_COUNT_RESET;
         for (int i = 0; i < MAX_KEYS; i++) key_ff[i] <= key_reset(i);
      end else if (csr_valid) begin
         if (csr_index == CSR_KEY_COUNT) begin
            kc_ff <= csr_data[IDX_W-1:0];
         end else begin
            for (int i = 0; i < MAX_KEYS; i++)
               if (csr_index == CSR_IDX_W'(i + 1)) key_ff[i] <= csr_data;
         end
      end
   end

   // handshake
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign s1_adv       = s1_valid_ff && rsp_free;
   assign req_tready   = !s1_valid_ff || rsp_free;
   assign req_acc      = req_tvalid && req_tready;
   assign s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   // key selection
   always_comb begin
      if (kc_ff < 3'd2)        keys_used = 3'd2;
      else if (kc_ff > MAX_N)  keys_used = MAX_N;
      else                     keys_used = kc_ff;
      last_idx  = keys_used - 3'd1;
      key_first = key_ff[0];
      key_last  = key_ff[0];
      for (int i = 0; i < MAX_KEYS; i++)
         if (last_idx == IDX_W'(i)) key_last = key_ff[i];
   end

   assign cmd    = req_tuser;
   assign tv     = req_tdata[TIME_W-1:0];
   assign target = req_tdata[TIME_W+IDX_W-1:TIME_W];

   // next state
   always_comb begin
      key_target = key_ff[0];
      for (int i = 0; i < MAX_KEYS; i++)
         if (target == IDX_W'(i)) key_target = key_ff[i];
      reject    = 1'b0;
      locate_en = 1'b0;
      cand_time = time_ff;
      unique case (cmd)
         CMD_ADVANCE: begin
            cand_time = sat_add(time_ff, tv);
            locate_en = 1'b1;
         end
         CMD_SET: begin
            cand_time = tv;
            locate_en = 1'b1;
         end
         CMD_GOTO, CMD_OFFSET: begin
            if (target > keys_used - 3'd2) begin
               reject = 1'b1;
            end else if (cmd == CMD_GOTO) begin
               cand_time = key_target;
            end else begin
               cand_time = sat_add(key_target, tv);
               locate_en = 1'b1;
            end
         end
         CMD_ZERO: begin
            cand_time = '0;
            locate_en = 1'b1;
         end
         default: begin
         end
      endcase

      // lowest inner key above the time wins
      loc_seg   = keys_used - 3'd2;
      loc_phase = RUN_RUNNING;
      for (int i = MAX_KEYS - 2; i >= 1; i--)
         if (IDX_W'(i + 1) < keys_used && cand_time < key_ff[i]) loc_seg = IDX_W'(i - 1);
      if (cand_time < key_first) begin
         loc_seg   = '0;
         loc_phase = RUN_UNDER;
      end else if (cand_time > key_last) begin
         loc_seg   = keys_used - 3'd2;
         loc_phase = RUN_OVER;
      end

      time_in  = time_ff;
      seg_in   = seg_ff;
      phase_in = phase_ff;
      rej_in   = reject;
      if (locate_en) begin
         time_in  = cand_time;
         seg_in   = loc_seg;
         phase_in = loc_phase;
      end else if (cmd == CMD_GOTO && !reject) begin
         time_in  = cand_time;
         seg_in   = target;
         phase_in = RUN_RUNNING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff     <= '0;
         seg_ff      <= '0;
         phase_ff    <= RUN_RUNNING;
         rej_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_acc) begin
            time_ff  <= time_in;
            seg_ff   <= seg_in;
            phase_ff <= phase_in;
            rej_ff   <= rej_in;
         end
      end
   end

   // result from the stored state
   always_comb begin
      if (time_ff < key_first)     clamped = key_first;
      else if (time_ff > key_last) clamped = key_last;
      else                         clamped = time_ff;

      seg_sat   = (seg_ff > MAX_SEG) ? MAX_SEG : seg_ff;
      key_start = key_ff[0];
      key_next  = key_ff[1];
      for (int i = 0; i < MAX_KEYS - 1; i++)
         if (seg_sat == IDX_W'(i)) begin
            key_start = key_ff[i];
            key_next  = key_ff[i + 1];
         end

      off      = sat_sub(time_ff, key_start);
      len_full = {key_next[TIME_W-1], key_next} - {key_start[TIME_W-1], key_start};
      if (len_full[TIME_W])            len = '0;
      else if (len_full[TIME_W-1])     len = '1;
      else                             len = len_full[OFFC_W-1:0];

      if (off[TIME_W-1])                  offc = '0;
      else if (off[OFFC_W-1:0] > len)     offc = len;
      else                                offc = off[OFFC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_time_ff    <= time_ff;
         out_clamped_ff <= clamped;
         out_seg_ff     <= seg_ff;
         out_off_ff     <= off;
         out_offc_ff    <= offc;
         out_run_ff     <= phase_ff;
         out_rej_ff     <= rej_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_rej_ff, out_run_ff, out_offc_ff, out_off_ff,
                        out_seg_ff, out_clamped_ff, out_time_ff};

   // under the first key the interval is always the first one
   a_under_first : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_run_ff == RUN_UNDER |-> out_seg_ff == '0)
      else $error("under-range result with nonzero interval");

   a_seg_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_seg_ff <= MAX_SEG)
      else $error("interval index beyond last interval");

   a_goto : assert property (@(posedge clock) disable iff (reset)
      req_acc && cmd == CMD_GOTO && target <= keys_used - 3'd2
      |=> seg_ff == $past(target) && phase_ff == RUN_RUNNING && !rej_ff)
      else $error("accepted jump did not land on its interval");

   a_reject_holds : assert property (@(posedge clock) disable iff (reset)
      req_acc && reject |=> time_ff == $past(time_ff) && seg_ff == $past(seg_ff))
      else $error("rejected jump changed the state");

endmodule

// ===== bench/keyframe_interval_tracker_test.sv =====
// Self-checking bench for the keyframe interval tracker: directed rows, then random phases.
// Drives request, response and register ports; checks every response beat against a local
// predictor or a typed result. Depends on kit_pkg and the keyframe_interval_tracker RTL.
module keyframe_interval_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kit_pkg::*;

   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int NUM_KEYS        = 7;
   localparam int SETTLE_CYCLES   = 3;
   localparam longint LEN_CAP     = 64'sh7FFF_FFFF;

   localparam logic [CMD_W-1:0]     CMD_RESERVED_LO = 3'd5;
   localparam logic [CMD_W-1:0]     CMD_RESERVED_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_BASE    = CSR_KEY_COUNT + 3'd1;

   typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct packed {
      time_type    time_now;
      time_type    time_clamped;
      idx_type     interval_now;
      time_type    interval_offset;
      logic [30:0] offset_clamped;
      run_type     run_state;
      logic        rejected;
   } tracker_result_type;

   typedef struct {
      row_kind_type          kind;
      logic [CMD_W-1:0]      cmd;
      time_type              value;     // also the register data for ROW_CSR
      idx_type               target;
      logic [CSR_IDX_W-1:0]  reg_index;
      tracker_result_type    result;
   } script_row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata  = '0;
   logic [CMD_W-1:0]     req_tuser  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [135:0]         rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [TIME_W-1:0]    csr_data   = '0;

   // predictor state
   time_type        track_time;
   idx_type         track_interval;
   run_type         track_run;
   time_type        key_shadow [NUM_KEYS];
   logic [2:0]      key_count_shadow;

   tracker_result_type pending_results [$];
   script_row_type     script [$];
   int              mismatches   = 0;
   int              quiet_cycles = 0;
   int              rsp_hold     = 0;
   bit              no_idle      = 1'b0;

   keyframe_interval_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic time_type clip_time(input longint v);
      if (v > longint'(TIME_MAX))
         return TIME_MAX;
      if (v < longint'(TIME_MIN))
         return TIME_MIN;
      return time_type'(v);
   endfunction

   function automatic int keys_active();
      return (key_count_shadow < 3'd2) ? 2 : int'(key_count_shadow);
   endfunction

   function automatic void place_time();
      int n;
      int i;
      n = keys_active();
      if (track_time < key_shadow[0]) begin
         track_run      = RUN_UNDER;
         track_interval = '0;
      end else if (track_time > key_shadow[n-1]) begin
         track_run      = RUN_OVER;
         track_interval = idx_type'(n - 2);
      end else begin
         track_run      = RUN_RUNNING;
         track_interval = idx_type'(n - 2);
         // walk down so the first key above the time wins
         for (i = n - 2; i >= 1; i--)
            if (track_time < key_shadow[i])
               track_interval = idx_type'(i - 1);
      end
   endfunction

   function automatic tracker_result_type track_step(input logic [CMD_W-1:0] cmd,
                                                     input time_type value,
                                                     input idx_type target);
      tracker_result_type r;
      int              n;
      int              seg;
      longint          len;
      longint          offc;
      logic            rej;
      n   = keys_active();
      rej = 1'b0;
      case (cmd)
         CMD_ADVANCE: begin
            track_time = clip_time(longint'(track_time) + longint'(value));
            place_time();
         end
         CMD_SET: begin
            track_time = value;
            place_time();
         end
         CMD_GOTO, CMD_OFFSET: begin
            if (int'(target) > n - 2) begin
               rej = 1'b1;
            end else if (cmd == CMD_GOTO) begin
               track_time     = key_shadow[target];
               track_interval = target;
               track_run      = RUN_RUNNING;
            end else begin
               track_time = clip_time(longint'(key_shadow[target]) + longint'(value));
               place_time();
            end
         end
         CMD_ZERO: begin
            track_time = '0;
            place_time();
         end
         default: ;
      endcase

      seg = int'(track_interval);
      if (seg > NUM_KEYS - 2)
         seg = NUM_KEYS - 2;

      r.time_now = track_time;
      if (track_time < key_shadow[0])
         r.time_clamped = key_shadow[0];
      else if (track_time > key_shadow[n-1])
         r.time_clamped = key_shadow[n-1];
      else
         r.time_clamped = track_time;
      r.interval_now    = track_interval;
      r.interval_offset = clip_time(longint'(track_time) - longint'(key_shadow[seg]));

      len = longint'(key_shadow[seg+1]) - longint'(key_shadow[seg]);
      if (len < 0)
         len = 0;
      if (len > LEN_CAP)
         len = LEN_CAP;
      offc = longint'(r.interval_offset);
      if (offc < 0)
         offc = 0;
      if (offc > len)
         offc = len;
      r.offset_clamped = offc[30:0];
      r.run_state      = track_run;
      r.rejected       = rej;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic time_type pick_time(input logic [CMD_W-1:0] cmd);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return $urandom_range(0, 1) ? TIME_MAX : TIME_MIN;
      if (r < 30)
         return time_type'($urandom());
      case (cmd)
         CMD_ADVANCE: return time_type'(int'($urandom_range(0, 4 * KEY_STEP)) - 2 * KEY_STEP);
         CMD_OFFSET:  return time_type'(int'($urandom_range(0, 3 * KEY_STEP)) - KEY_STEP / 2);
         default:     return clip_time(longint'(key_shadow[$urandom_range(0, keys_active() - 1)])
                                       + longint'(int'($urandom_range(0, 8)) - 4));
      endcase
   endfunction

   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_beat(input logic [CMD_W-1:0] cmd, input time_type value,
                            input idx_type target, input bit typed,
                            input tracker_result_type typed_result);
      int                 gap;
      tracker_result_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, target, value};
      predicted = track_step(cmd, value, target);
      pending_results.push_back(typed ? typed_result : predicted);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [TIME_W-1:0] data);
      settle_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (index == CSR_KEY_COUNT)
         key_count_shadow = data[2:0];
      else
         key_shadow[int'(index) - 1] = data;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // mode 0: close sorted keys, 1: full-range sorted with extremes at the ends,
   // 2: random order, 3: sorted with many equal keys
   task automatic program_keys(input int mode, input logic [2:0] count);
      int k [$];
      int step;
      int i;
      k = {};
      case (mode)
         0, 3: begin
            k.push_back(int'($urandom_range(0, 8 * KEY_STEP)) - 4 * KEY_STEP);
            repeat (NUM_KEYS - 1) begin
               if (mode == 3)
                  step = $urandom_range(0, 1) ? KEY_STEP : 0;
               else
                  step = $urandom_range(0, 3 * KEY_STEP);
               k.push_back(k[$] + step);
            end
         end
         default: begin
            repeat (NUM_KEYS) k.push_back(int'($urandom()));
            if (mode == 1) begin
               k.sort();
               k[0]          = TIME_MIN;
               k[NUM_KEYS-1] = TIME_MAX;
            end
         end
      endcase
      write_reg(CSR_KEY_COUNT, {29'b0, count});
      for (i = 0; i < NUM_KEYS; i++)
         write_reg(CSR_IDX_W'(int'(CSR_KEY_BASE) + i), k[i]);
   endtask

   task automatic script_item(input logic [CMD_W-1:0] cmd, input time_type value,
                              input idx_type target);
      script_row_type row;
      row.kind      = ROW_ITEM;
      row.cmd       = cmd;
      row.value     = value;
      row.target    = target;
      row.reg_index = '0;
      row.result    = '0;
      script.push_back(row);
   endtask

   task automatic script_typed(input logic [CMD_W-1:0] cmd, input time_type value,
                               input idx_type target, input time_type now,
                               input time_type clamped, input idx_type interval,
                               input time_type offset, input logic [30:0] offset_clamped,
                               input run_type run, input logic rejected);
      script_row_type row;
      row.kind                  = ROW_TYPED;
      row.cmd                   = cmd;
      row.value                 = value;
      row.target                = target;
      row.reg_index             = '0;
      row.result.time_now       = now;
      row.result.time_clamped   = clamped;
      row.result.interval_now   = interval;
      row.result.interval_offset = offset;
      row.result.offset_clamped = offset_clamped;
      row.result.run_state      = run;
      row.result.rejected       = rejected;
      script.push_back(row);
   endtask

   task automatic script_csr(input logic [CSR_IDX_W-1:0] index, input time_type data);
      script_row_type row;
      row.kind      = ROW_CSR;
      row.cmd       = '0;
      row.value     = data;
      row.target    = '0;
      row.reg_index = index;
      row.result    = '0;
      script.push_back(row);
   endtask

   // ---------------------------------------------------------------- response side

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tracker_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_hold = no_idle ? 0 : $urandom_range(0, 7);
         if (pending_results.size() == 0) begin
            $display("%0t: response beat with nothing expected, got %h", $realtime, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("time_now", want.time_now, rsp_tdata[31:0]);
            check_field("time_clamped", want.time_clamped, rsp_tdata[63:32]);
            check_field("interval_now", 32'(want.interval_now), 32'(rsp_tdata[66:64]));
            check_field("interval_offset", want.interval_offset, rsp_tdata[98:67]);
            check_field("offset_clamped", 32'(want.offset_clamped), 32'(rsp_tdata[129:99]));
            check_field("run_state", 32'(want.run_state), 32'(rsp_tdata[131:130]));
            check_field("index_rejected", 32'(want.rejected), 32'(rsp_tdata[132]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      int               i;
      int               phase;
      int               item;
      int               r;
      int               n;
      logic [CMD_W-1:0] cmd;
      idx_type          target;
      logic [2:0]       count;

      key_count_shadow = KEY_COUNT_RESET;
      for (i = 0; i < NUM_KEYS; i++)
         key_shadow[i] = time_type'(i * KEY_STEP);
      track_time     = '0;
      track_interval = '0;
      track_run      = RUN_RUNNING;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset keys 0 and 1.0, two keys in use
      script_typed(CMD_ZERO, 32'sh0, 3'd0, 32'sh0, 32'sh0, 3'd0, 32'sh0, 31'h0,
                   RUN_RUNNING, 1'b0);
      script_typed(CMD_ADVANCE, TIME_MAX, 3'd0, TIME_MAX, 32'sh10000, 3'd0, TIME_MAX,
                   31'h10000, RUN_OVER, 1'b0);
      script_typed(CMD_ADVANCE, 32'sh1, 3'd0, TIME_MAX, 32'sh10000, 3'd0, TIME_MAX,
                   31'h10000, RUN_OVER, 1'b0);
      script_typed(CMD_SET, TIME_MIN, 3'd0, TIME_MIN, 32'sh0, 3'd0, TIME_MIN, 31'h0,
                   RUN_UNDER, 1'b0);
      script_typed(CMD_ADVANCE, TIME_MIN, 3'd0, TIME_MIN, 32'sh0, 3'd0, TIME_MIN, 31'h0,
                   RUN_UNDER, 1'b0);
      script_typed(CMD_GOTO, 32'sh0, 3'd1, TIME_MIN, 32'sh0, 3'd0, TIME_MIN, 31'h0,
                   RUN_UNDER, 1'b1);
      script_typed(CMD_OFFSET, 32'sh5, 3'd7, TIME_MIN, 32'sh0, 3'd0, TIME_MIN, 31'h0,
                   RUN_UNDER, 1'b1);
      script_typed(CMD_RESERVED_LO, 32'sh1234, 3'd0, TIME_MIN, 32'sh0, 3'd0, TIME_MIN,
                   31'h0, RUN_UNDER, 1'b0);
      script_typed(CMD_GOTO, 32'sh0, 3'd0, 32'sh0, 32'sh0, 3'd0, 32'sh0, 31'h0,
                   RUN_RUNNING, 1'b0);
      // landing on the last key stays in the last interval
      script_typed(CMD_OFFSET, 32'sh10000, 3'd0, 32'sh10000, 32'sh10000, 3'd0, 32'sh10000,
                   31'h10000, RUN_RUNNING, 1'b0);
      script_typed(CMD_RESERVED_HI, -32'sh1, 3'd7, 32'sh10000, 32'sh10000, 3'd0, 32'sh10000,
                   31'h10000, RUN_RUNNING, 1'b0);
      script_item(CMD_SET, 32'sh8000, 3'd0);

      // seven keys, extremes at both ends, a zero-length interval in the middle
      script_csr(CSR_KEY_COUNT, 32'sd7);
      script_csr(CSR_KEY_BASE + 3'd0, TIME_MIN);
      script_csr(CSR_KEY_BASE + 3'd1, -32'sh10000);
      script_csr(CSR_KEY_BASE + 3'd2, 32'sh0);
      script_csr(CSR_KEY_BASE + 3'd3, 32'sh10000);
      script_csr(CSR_KEY_BASE + 3'd4, 32'sh10000);
      script_csr(CSR_KEY_BASE + 3'd5, 32'sh50000);
      script_csr(CSR_KEY_BASE + 3'd6, TIME_MAX);
      script_item(CMD_SET, 32'sh10000, 3'd0);
      script_item(CMD_GOTO, 32'sh0, 3'd3);
      script_item(CMD_GOTO, 32'sh0, 3'd4);
      script_item(CMD_GOTO, 32'sh0, 3'd6);
      script_item(CMD_OFFSET, TIME_MAX, 3'd5);
      script_item(CMD_ADVANCE, 32'sh1, 3'd0);
      script_item(CMD_SET, TIME_MIN, 3'd0);
      script_item(CMD_OFFSET, -32'sh1, 3'd0);
      script_item(CMD_ZERO, 32'sh0, 3'd0);
      script_item(CMD_ADVANCE, -32'sh18000, 3'd0);

      // count below two acts as two; first interval made negative in length
      script_csr(CSR_KEY_COUNT, 32'sd1);
      script_csr(CSR_KEY_BASE + 3'd0, 32'sh20000);
      script_item(CMD_SET, TIME_MAX, 3'd0);
      script_item(CMD_SET, 32'sh0, 3'd0);
      script_csr(CSR_KEY_COUNT, 32'sd0);
      script_item(CMD_ZERO, 32'sh0, 3'd0);

      foreach (script[i]) begin
         case (script[i].kind)
            ROW_CSR:   write_reg(script[i].reg_index, script[i].value);
            ROW_TYPED: send_beat(script[i].cmd, script[i].value, script[i].target, 1'b1,
                                 script[i].result);
            default:   send_beat(script[i].cmd, script[i].value, script[i].target, 1'b0, '0);
         endcase
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         no_idle = (phase % 5 == 3);
         if (phase % 3 == 0)
            count = 3'd7;
         else if (phase % 3 == 1)
            count = 3'd2;
         else
            count = $urandom_range(0, 7);
         program_keys(phase % 4, count);
         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            // hold off mid-phase until the pipeline is empty
            if (item == ITEMS_PER_PHASE / 2)
               settle_idle();
            r = $urandom_range(0, 99);
            if (r < 35)
               cmd = CMD_ADVANCE;
            else if (r < 55)
               cmd = CMD_SET;
            else if (r < 70)
               cmd = CMD_GOTO;
            else if (r < 85)
               cmd = CMD_OFFSET;
            else if (r < 92)
               cmd = CMD_ZERO;
            else
               cmd = CMD_RESERVED_LO + 3'($urandom_range(0, 2));
            n = keys_active();
            if ($urandom_range(0, 4) != 0)
               target = idx_type'($urandom_range(0, n - 2));
            else
               target = idx_type'($urandom_range(0, 7));
            send_beat(cmd, pick_time(cmd), target, 1'b0, '0);
         end
      end

      settle_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
